// File: rtl/ncw_pkg.sv
// Shared types and constants for the New Reno congestion window block.
package ncw_pkg;

    localparam int TIME_BITS = 48;
    localparam int BYTE_BITS = 32;
    localparam int RTT_BITS  = 32;
    localparam int MTU_BITS  = 16;
    localparam int CWIN_BITS = 24;
    localparam int OUT_BITS  = 48;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    // event kinds
    localparam logic [2:0] K_ACK      = 3'd0;
    localparam logic [2:0] K_ECN      = 3'd1;
    localparam logic [2:0] K_REPEAT   = 3'd2;
    localparam logic [2:0] K_TIMEOUT  = 3'd3;
    localparam logic [2:0] K_SPURIOUS = 3'd4;
    localparam logic [2:0] K_RESET    = 3'd5;
    localparam logic [2:0] K_SEED     = 3'd6;
    localparam logic [2:0] K_IGNORE   = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_WIN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_WIN  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MTU      = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MPATH    = 2'd3;

    localparam logic [CWIN_BITS-1:0] INIT_WIN_RST = 24'd15360;
    localparam logic [CWIN_BITS-1:0] MIN_WIN_RST  = 24'd3072;
    localparam logic [MTU_BITS-1:0]  MTU_RST      = 16'd1440;

    localparam logic PH_SLOW  = 1'b0;
    localparam logic PH_AVOID = 1'b1;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
    } t_stat;

endpackage

// File: rtl/ncw_ctrl.sv
// Sequencer for one event: capture, multiply, sum, serial divide, commit.
module ncw_ctrl #(
    parameter int WINDOW_BITS = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    input  ncw_pkg::t_stat i_stat,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output ncw_pkg::t_cmd o_cmd
);

    localparam int CW = $clog2(WINDOW_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                if (i_stat.need_div) begin
                    n_cnt   = CW'(WINDOW_BITS - 1);
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/ncw_dpath.sv
// Window state, growth multiplier, serial divider and event update logic.
module ncw_dpath #(
    parameter int WINDOW_BITS = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ncw_pkg::t_cmd                         i_cmd,
    output ncw_pkg::t_stat                        o_stat,
    input  logic [ncw_pkg::CWIN_BITS-1:0]         i_cfg_init_win,
    input  logic [ncw_pkg::CWIN_BITS-1:0]         i_cfg_min_win,
    input  logic [ncw_pkg::MTU_BITS-1:0]          i_cfg_mtu,
    input  logic                                  i_cfg_mpath,
    input  logic [2:0]                            i_kind,
    input  logic [ncw_pkg::BYTE_BITS-1:0]         i_byte_count,
    input  logic [ncw_pkg::TIME_BITS-1:0]         i_now_time,
    input  logic [ncw_pkg::RTT_BITS-1:0]          i_round_trip,
    input  logic [ncw_pkg::TIME_BITS-1:0]         i_next_sequence,
    input  logic [ncw_pkg::TIME_BITS-1:0]         i_acked_sequence,
    input  logic [ncw_pkg::TIME_BITS-1:0]         i_ack_sent_time,
    output logic [ncw_pkg::OUT_BITS-1:0]          o_window,
    output logic [ncw_pkg::OUT_BITS-1:0]          o_threshold,
    output logic                                  o_phase,
    output logic                                  o_recovery_entered
);

    localparam int W  = WINDOW_BITS;
    localparam int TB = ncw_pkg::TIME_BITS;
    localparam int BW = ((W > ncw_pkg::BYTE_BITS) ? W : ncw_pkg::BYTE_BITS) + 1;
    localparam int PB = ncw_pkg::BYTE_BITS + ncw_pkg::MTU_BITS;
    localparam int PW = ((W > PB) ? W : PB) + 1;
    localparam int XW = ((W > ncw_pkg::OUT_BITS) ? W : ncw_pkg::OUT_BITS) + 1;
    localparam logic [W-1:0] WMAX = '1;

    // captured event
    logic [2:0]                    r_kind;
    logic [ncw_pkg::BYTE_BITS-1:0] r_bytes;
    logic [TB-1:0]                 r_now;
    logic [ncw_pkg::RTT_BITS-1:0]  r_rtt;
    logic [TB-1:0]                 r_next;
    logic [TB-1:0]                 r_acked;
    logic [TB-1:0]                 r_sent;

    // growth path
    logic [PB-1:0] r_prod;
    logic [W-1:0]  r_total;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;

    // connection state
    logic          r_phase, n_phase;
    logic [W-1:0]  r_window, n_window;
    logic [W-1:0]  r_thr, n_thr;
    logic [TB-1:0] r_rtime, n_rtime;
    logic [TB-1:0] r_rseq, n_rseq;
    logic [W-1:0]  r_grow, n_grow;
    logic          n_entered;

    // result register
    logic [ncw_pkg::OUT_BITS-1:0] r_o_window, r_o_thr;
    logic                         r_o_phase, r_o_entered;

    logic [PW-1:0] prod_x;
    logic [W-1:0]  prod_c;
    logic [W:0]    total_s;
    logic [W-1:0]  total_c;
    logic [W:0]    trial;
    logic          trial_ge;

    logic [TB-1:0] elapsed;
    logic          acked_past;
    logic [BW-1:0] ss_sum;
    logic [W-1:0]  ss_win;
    logic [W:0]    av_sum;
    logic [W-1:0]  av_win;
    logic [W-1:0]  half_win, min_win, rec_thr;
    logic [W-1:0]  twice;
    logic [BW-1:0] bytes_x;
    logic [W-1:0]  seed_b;
    logic [XW-1:0] win_x, thr_x;

    assign o_stat.need_div = (r_kind == ncw_pkg::K_ACK) && (r_phase == ncw_pkg::PH_AVOID)
                             && (r_window != '0);

    // clamp product to window width, then saturating add of the carried remainder
    assign prod_x  = PW'(r_prod);
    assign prod_c  = (prod_x > PW'(WMAX)) ? WMAX : prod_x[W-1:0];
    assign total_s = {1'b0, prod_c} + {1'b0, r_grow};
    assign total_c = total_s[W] ? WMAX : total_s[W-1:0];

    // restoring divider, one quotient bit per cycle; divisor is r_window
    assign trial    = {r_rem, r_quo[W-1]};
    assign trial_ge = (trial >= {1'b0, r_window});
    always_comb begin
        n_rem = trial_ge ? W'(trial - {1'b0, r_window}) : trial[W-1:0];
        n_quo = {r_quo[W-2:0], trial_ge};
    end

    assign elapsed    = r_now - r_rtime;
    assign acked_past = i_cfg_mpath ? (r_rtime <= r_sent) : (r_rseq <= r_acked);

    assign bytes_x = BW'(r_bytes);
    assign ss_sum  = BW'(r_window) + bytes_x;
    assign ss_win  = (ss_sum > BW'(WMAX)) ? WMAX : ss_sum[W-1:0];
    assign seed_b  = (bytes_x > BW'(WMAX)) ? WMAX : bytes_x[W-1:0];

    assign av_sum  = {1'b0, r_window} + {1'b0, r_quo};
    assign av_win  = av_sum[W] ? WMAX : av_sum[W-1:0];

    assign half_win = r_window >> 1;
    assign min_win  = W'(i_cfg_min_win);
    assign rec_thr  = (half_win < min_win) ? min_win : half_win;
    assign twice    = r_thr[W-1] ? WMAX : {r_thr[W-2:0], 1'b0};

    always_comb begin
        n_phase   = r_phase;
        n_window  = r_window;
        n_thr     = r_thr;
        n_rtime   = r_rtime;
        n_rseq    = r_rseq;
        n_grow    = r_grow;
        n_entered = 1'b0;
        case (r_kind)
            ncw_pkg::K_ACK: begin
                if (r_phase == ncw_pkg::PH_SLOW) begin
                    n_window = ss_win;
                    if (ss_win >= r_thr) begin
                        n_phase = ncw_pkg::PH_AVOID;
                    end
                end else if (r_window == '0) begin
                    // zero window: divisor taken as one
                    n_window = r_total;
                    n_grow   = '0;
                end else begin
                    n_window = av_win;
                    n_grow   = r_rem;
                end
            end
            ncw_pkg::K_ECN, ncw_pkg::K_REPEAT, ncw_pkg::K_TIMEOUT: begin
                if ((elapsed > TB'(r_rtt)) || acked_past) begin
                    n_thr = rec_thr;
                    if (r_kind == ncw_pkg::K_TIMEOUT) begin
                        n_window = min_win;
                        n_phase  = ncw_pkg::PH_SLOW;
                    end else begin
                        n_window = rec_thr;
                        n_phase  = ncw_pkg::PH_AVOID;
                    end
                    n_rtime   = r_now;
                    n_rseq    = r_next;
                    n_grow    = '0;
                    n_entered = 1'b1;
                end
            end
            ncw_pkg::K_SPURIOUS: begin
                if ((elapsed < TB'(r_rtt)) && !acked_past && (r_thr != WMAX)
                        && (r_window < twice)) begin
                    n_window = twice;
                    n_phase  = ncw_pkg::PH_AVOID;
                end
            end
            ncw_pkg::K_RESET: begin
                n_phase  = ncw_pkg::PH_SLOW;
                n_window = W'(i_cfg_init_win);
                n_thr    = WMAX;
                n_rtime  = '0;
                n_rseq   = '0;
                n_grow   = '0;
            end
            ncw_pkg::K_SEED: begin
                if ((r_phase == ncw_pkg::PH_SLOW) && (r_thr == WMAX) && (seed_b > r_window)) begin
                    n_window = seed_b;
                    n_thr    = seed_b;
                    n_phase  = ncw_pkg::PH_AVOID;
                end
            end
            default: begin
                // ignore: state unchanged
            end
        endcase
    end

    assign win_x = XW'(n_window);
    assign thr_x = XW'(n_thr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_bytes <= i_byte_count;
            r_now   <= i_now_time;
            r_rtt   <= i_round_trip;
            r_next  <= i_next_sequence;
            r_acked <= i_acked_sequence;
            r_sent  <= i_ack_sent_time;
        end
        if (i_cmd.mul) begin
            r_prod <= r_bytes * i_cfg_mtu;
        end
        if (i_cmd.sum) begin
            r_total <= total_c;
            r_quo   <= total_c;
            r_rem   <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (i_cmd.commit) begin
            r_o_window  <= win_x[ncw_pkg::OUT_BITS-1:0];
            r_o_thr     <= (n_thr == WMAX) ? '0 : thr_x[ncw_pkg::OUT_BITS-1:0];
            r_o_phase   <= n_phase;
            r_o_entered <= n_entered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ncw_pkg::PH_SLOW;
            r_window <= W'(ncw_pkg::INIT_WIN_RST);
            r_thr    <= WMAX;
            r_rtime  <= '0;
            r_rseq   <= '0;
            r_grow   <= '0;
        end else if (i_cmd.commit) begin
            r_phase  <= n_phase;
            r_window <= n_window;
            r_thr    <= n_thr;
            r_rtime  <= n_rtime;
            r_rseq   <= n_rseq;
            r_grow   <= n_grow;
        end
    end

    assign o_window           = r_o_window;
    assign o_threshold        = r_o_thr;
    assign o_phase            = r_o_phase;
    assign o_recovery_entered = r_o_entered;

endmodule

// File: rtl/newreno_congestion_window_core.sv
// New Reno congestion window for one connection. One event is taken at a time: the input
// stalls from the transfer until the event is committed. For non-growth events and
// slow-start acks, the event passes capture, multiply, sum and commit before result valid
// rises. An ack in congestion avoidance with a nonzero window also runs the restoring
// divider, which produces one quotient bit per cycle, between sum and commit. The input
// reopens the cycle after the commit. The result sits in an output register, so the next
// event can be taken while a result waits; the commit of that next event waits for the
// register to drain. Configuration writes are always ready and must only be issued while
// no event is in flight; initial_window is used at the next reset event (a port reset uses
// the default value).
module newreno_congestion_window_core #(
    parameter int WINDOW_BITS = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [2:0]                            i_kind,
    input  logic [ncw_pkg::BYTE_BITS-1:0]         i_byte_count,
    input  logic [ncw_pkg::TIME_BITS-1:0]         i_now_time,
    input  logic [ncw_pkg::RTT_BITS-1:0]          i_round_trip,
    input  logic [ncw_pkg::TIME_BITS-1:0]         i_next_sequence,
    input  logic [ncw_pkg::TIME_BITS-1:0]         i_acked_sequence,
    input  logic [ncw_pkg::TIME_BITS-1:0]         i_ack_sent_time,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [ncw_pkg::OUT_BITS-1:0]          o_window,
    output logic [ncw_pkg::OUT_BITS-1:0]          o_threshold,
    output logic                                  o_phase,
    output logic                                  o_recovery_entered,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ncw_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [ncw_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    logic [ncw_pkg::CWIN_BITS-1:0] r_cfg_init_win;
    logic [ncw_pkg::CWIN_BITS-1:0] r_cfg_min_win;
    logic [ncw_pkg::MTU_BITS-1:0]  r_cfg_mtu;
    logic                          r_cfg_mpath;

    ncw_pkg::t_cmd  cmd;
    ncw_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_init_win <= ncw_pkg::INIT_WIN_RST;
            r_cfg_min_win  <= ncw_pkg::MIN_WIN_RST;
            r_cfg_mtu      <= ncw_pkg::MTU_RST;
            r_cfg_mpath    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ncw_pkg::CFG_INIT_WIN: r_cfg_init_win <= i_cfg_data;
                ncw_pkg::CFG_MIN_WIN:  r_cfg_min_win  <= i_cfg_data;
                ncw_pkg::CFG_MTU:      r_cfg_mtu      <= i_cfg_data[ncw_pkg::MTU_BITS-1:0];
                ncw_pkg::CFG_MPATH:    r_cfg_mpath    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ncw_ctrl #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ncw_dpath #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_init_win     (r_cfg_init_win),
        .i_cfg_min_win      (r_cfg_min_win),
        .i_cfg_mtu          (r_cfg_mtu),
        .i_cfg_mpath        (r_cfg_mpath),
        .i_kind             (i_kind),
        .i_byte_count       (i_byte_count),
        .i_now_time         (i_now_time),
        .i_round_trip       (i_round_trip),
        .i_next_sequence    (i_next_sequence),
        .i_acked_sequence   (i_acked_sequence),
        .i_ack_sent_time    (i_ack_sent_time),
        .o_window           (o_window),
        .o_threshold        (o_threshold),
        .o_phase            (o_phase),
        .o_recovery_entered (o_recovery_entered)
    );

endmodule

// File: rtl/ncw_checker.sv
// Port-level checks for the congestion window core, bound to the top level.
module ncw_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [ncw_pkg::OUT_BITS-1:0]      o_window,
    input logic [ncw_pkg::OUT_BITS-1:0]      o_threshold,
    input logic                              o_phase,
    input logic                              o_recovery_entered
);

    // one event at a time: a transfer in closes the input
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after a transfer");

    // a new result only appears after the block was busy
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an event in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_window)
            && $stable(o_threshold) && $stable(o_phase) && $stable(o_recovery_entered)))
        else $error("stalled result changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset did not clear handshake state");

endmodule

bind newreno_congestion_window_core ncw_checker u_ncw_checker (.*);
